[design/assert_macros.svh]
// Assertion macros used by euler_to_rotation_matrix_unit.
// No dependencies. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[design/e2rm_pkg.sv]
// Package for the Euler angle to rotation matrix unit: widths, types, CORDIC table.
// No dependencies.
package e2rm_pkg;

  localparam int ANGLE_BITS    = 16;  // 8..24
  localparam int FRACTION_BITS = 14;  // 8..30
  localparam int OUT_BITS      = FRACTION_BITS + 2;
  localparam int ROUND_SHIFT   = 30 - FRACTION_BITS;
  localparam int CORDIC_STEPS  = 30;
  localparam int LANES         = 3;

  // lane order: rotation about x, y, z
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  typedef logic [ANGLE_BITS-1:0]   angle_t;
  typedef logic signed [31:0]      q30_t;
  typedef logic signed [63:0]      prod_t;
  typedef logic signed [32:0]      sum_t;
  typedef logic signed [OUT_BITS-1:0] out_t;

  localparam q30_t CORDIC_GAIN = 32'sh26DD3B6A;

  // arctan(2^-i) in 32-bit turns
  localparam q30_t ATAN_TURN32 [CORDIC_STEPS] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
    32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
    32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
  };

endpackage

[design/euler_to_rotation_matrix_unit.sv]
// Euler angle (Z-Y-X) to rotation matrix unit, fully pipelined.
// Depends on e2rm_pkg and assert_macros.svh.
//
// Takes a word of three binary angles (a full turn is 2^ANGLE_BITS) and
// returns a word of the nine entries of R = Rz*Ry*Rx, row-major, each signed
// Q1.FRACTION_BITS, rounded and clamped to +/-1.0. Throughput is one word per
// clock unless the output stalls. There are 38 register stages; they are:
// one stage of quadrant reduction, 30 CORDIC stages (one micro-rotation each,
// three angle lanes side by side), one quadrant fix-up stage, two stages for
// the first product layer (multiply, round), two for the second (multiply,
// round), one stage of sums and a final round/clamp output register. The whole
// pipe moves as one; it holds only while a finished word sits on the output and
// out_stall is high, and in_stall mirrors that. Words never depend on one
// another and there is no configuration or reset-time sweep.
module euler_to_rotation_matrix_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  e2rm_pkg::angle_t      in_angle_x,
  input  e2rm_pkg::angle_t      in_angle_y,
  input  e2rm_pkg::angle_t      in_angle_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output e2rm_pkg::out_t        out_m00,
  output e2rm_pkg::out_t        out_m01,
  output e2rm_pkg::out_t        out_m02,
  output e2rm_pkg::out_t        out_m10,
  output e2rm_pkg::out_t        out_m11,
  output e2rm_pkg::out_t        out_m12,
  output e2rm_pkg::out_t        out_m20,
  output e2rm_pkg::out_t        out_m21,
  output e2rm_pkg::out_t        out_m22
);
  import e2rm_pkg::*;

  `include "assert_macros.svh"

  // pipeline register count: CORDIC 0..30, quadrant fix, A, B, C, D, E, F
  localparam int NSTG = CORDIC_STEPS + 8;

  // first product layer
  localparam int P_CZSY = 0;
  localparam int P_SZSY = 1;
  localparam int P_CZCY = 2;
  localparam int P_SZCY = 3;
  localparam int P_SZCX = 4;
  localparam int P_SZSX = 5;
  localparam int P_CZCX = 6;
  localparam int P_CZSX = 7;
  localparam int P_CYSX = 8;
  localparam int P_CYCX = 9;
  localparam int NPROD  = 10;

  // second product layer
  localparam int S_CZSYSX = 0;
  localparam int S_CZSYCX = 1;
  localparam int S_SZSYSX = 2;
  localparam int S_SZSYCX = 3;
  localparam int NSEC     = 4;

  // matrix entries
  localparam int M00 = 0;
  localparam int M01 = 1;
  localparam int M02 = 2;
  localparam int M10 = 3;
  localparam int M11 = 4;
  localparam int M12 = 5;
  localparam int M20 = 6;
  localparam int M21 = 7;
  localparam int M22 = 8;
  localparam int NENT = 9;

  localparam logic signed [33:0] OUT_RND = (34'sd1 <<< ROUND_SHIFT) >>> 1;
  localparam logic signed [33:0] OUT_LIM = 34'sd1 <<< FRACTION_BITS;

  // Q30 product with round-half-up, floor shift
  function automatic q30_t rnd_q30(input prod_t p);
    prod_t s;
    s = p + (64'sd1 <<< 29);
    return q30_t'(s >>> 30);
  endfunction

  // Q30 to output format with rounding and clamp
  function automatic out_t to_out(input sum_t v);
    logic signed [33:0] w;
    w = {v[32], v} + OUT_RND;
    w = w >>> ROUND_SHIFT;
    if (w > OUT_LIM) begin
      w = OUT_LIM;
    end else if (w < -OUT_LIM) begin
      w = -OUT_LIM;
    end
    return out_t'(w);
  endfunction

  logic            en;
  logic [NSTG-1:0] vld_r;

  assign out_valid = vld_r[NSTG-1];
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // ---- quadrant reduction into CORDIC stage 0 ----
  angle_t in_ang [LANES];
  assign in_ang[LANE_X] = in_angle_x;
  assign in_ang[LANE_Y] = in_angle_y;
  assign in_ang[LANE_Z] = in_angle_z;

  q30_t       cx_r [CORDIC_STEPS+1][LANES];
  q30_t       cy_r [CORDIC_STEPS+1][LANES];
  q30_t       cz_r [CORDIC_STEPS+1][LANES];
  logic [1:0] quad_r [CORDIC_STEPS+1][LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_reduce
    logic [31:0] turn;
    logic [31:0] turn_ofs;
    logic [1:0]  quad;
    assign turn     = {in_ang[l], {(32 - ANGLE_BITS){1'b0}}};
    assign turn_ofs = turn + 32'h2000_0000;
    assign quad     = turn_ofs[31:30];

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[0][l]   <= CORDIC_GAIN;
        cy_r[0][l]   <= '0;
        cz_r[0][l]   <= q30_t'(turn - {quad, 30'd0});
        quad_r[0][l] <= quad;
      end
    end
  end

  // ---- CORDIC micro-rotations, one per stage ----
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      q30_t dx;
      q30_t dy;
      assign dx = cy_r[k][l] >>> k;
      assign dy = cx_r[k][l] >>> k;

      always_ff @(posedge clk) begin
        if (en) begin
          if (cz_r[k][l] >= 0) begin
            cx_r[k+1][l] <= cx_r[k][l] - dx;
            cy_r[k+1][l] <= cy_r[k][l] + dy;
            cz_r[k+1][l] <= cz_r[k][l] - ATAN_TURN32[k];
          end else begin
            cx_r[k+1][l] <= cx_r[k][l] + dx;
            cy_r[k+1][l] <= cy_r[k][l] - dy;
            cz_r[k+1][l] <= cz_r[k][l] + ATAN_TURN32[k];
          end
          quad_r[k+1][l] <= quad_r[k][l];
        end
      end
    end
  end

  // ---- quadrant fix-up: rotate (cos, sin) by quadrant * 90 degrees ----
  q30_t cos_r [LANES];
  q30_t sin_r [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_quad
    q30_t fx;
    q30_t fy;
    assign fx = cx_r[CORDIC_STEPS][l];
    assign fy = cy_r[CORDIC_STEPS][l];

    always_ff @(posedge clk) begin
      if (en) begin
        unique case (quad_r[CORDIC_STEPS][l])
          2'd0: begin cos_r[l] <= fx;  sin_r[l] <= fy;  end
          2'd1: begin cos_r[l] <= -fy; sin_r[l] <= fx;  end
          2'd2: begin cos_r[l] <= -fx; sin_r[l] <= -fy; end
          default: begin cos_r[l] <= fy; sin_r[l] <= -fx; end
        endcase
      end
    end
  end

  // ---- stage A: first product layer, raw ----
  prod_t pa_r [NPROD];
  q30_t  sxa_r, cxa_r, sya_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[P_CZSY] <= cos_r[LANE_Z] * sin_r[LANE_Y];
      pa_r[P_SZSY] <= sin_r[LANE_Z] * sin_r[LANE_Y];
      pa_r[P_CZCY] <= cos_r[LANE_Z] * cos_r[LANE_Y];
      pa_r[P_SZCY] <= sin_r[LANE_Z] * cos_r[LANE_Y];
      pa_r[P_SZCX] <= sin_r[LANE_Z] * cos_r[LANE_X];
      pa_r[P_SZSX] <= sin_r[LANE_Z] * sin_r[LANE_X];
      pa_r[P_CZCX] <= cos_r[LANE_Z] * cos_r[LANE_X];
      pa_r[P_CZSX] <= cos_r[LANE_Z] * sin_r[LANE_X];
      pa_r[P_CYSX] <= cos_r[LANE_Y] * sin_r[LANE_X];
      pa_r[P_CYCX] <= cos_r[LANE_Y] * cos_r[LANE_X];
      sxa_r        <= sin_r[LANE_X];
      cxa_r        <= cos_r[LANE_X];
      sya_r        <= sin_r[LANE_Y];
    end
  end

  // ---- stage B: round first layer ----
  q30_t rb_r [NPROD];
  q30_t sxb_r, cxb_r, syb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NPROD; i++) begin
        rb_r[i] <= rnd_q30(pa_r[i]);
      end
      sxb_r <= sxa_r;
      cxb_r <= cxa_r;
      syb_r <= sya_r;
    end
  end

  // ---- stage C: second product layer, raw ----
  prod_t pc_r [NSEC];
  q30_t  rc_r [NPROD];
  q30_t  syc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r[S_CZSYSX] <= rb_r[P_CZSY] * sxb_r;
      pc_r[S_CZSYCX] <= rb_r[P_CZSY] * cxb_r;
      pc_r[S_SZSYSX] <= rb_r[P_SZSY] * sxb_r;
      pc_r[S_SZSYCX] <= rb_r[P_SZSY] * cxb_r;
      rc_r           <= rb_r;
      syc_r          <= syb_r;
    end
  end

  // ---- stage D: round second layer ----
  q30_t rd_r [NSEC];
  q30_t rdd_r [NPROD];
  q30_t syd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NSEC; i++) begin
        rd_r[i] <= rnd_q30(pc_r[i]);
      end
      rdd_r <= rc_r;
      syd_r <= syc_r;
    end
  end

  // ---- stage E: sums in Q30 ----
  sum_t ent_r [NENT];

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r[M00] <= sum_t'(rdd_r[P_CZCY]);
      ent_r[M01] <= sum_t'(rd_r[S_CZSYSX]) - sum_t'(rdd_r[P_SZCX]);
      ent_r[M02] <= sum_t'(rd_r[S_CZSYCX]) + sum_t'(rdd_r[P_SZSX]);
      ent_r[M10] <= sum_t'(rdd_r[P_SZCY]);
      ent_r[M11] <= sum_t'(rd_r[S_SZSYSX]) + sum_t'(rdd_r[P_CZCX]);
      ent_r[M12] <= sum_t'(rd_r[S_SZSYCX]) - sum_t'(rdd_r[P_CZSX]);
      ent_r[M20] <= -sum_t'(syd_r);
      ent_r[M21] <= sum_t'(rdd_r[P_CYSX]);
      ent_r[M22] <= sum_t'(rdd_r[P_CYCX]);
    end
  end

  // ---- stage F: round to output format, clamp, output register ----
  out_t out_r [NENT];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NENT; i++) begin
        out_r[i] <= to_out(ent_r[i]);
      end
    end
  end

  assign out_m00 = out_r[M00];
  assign out_m01 = out_r[M01];
  assign out_m02 = out_r[M02];
  assign out_m10 = out_r[M10];
  assign out_m11 = out_r[M11];
  assign out_m12 = out_r[M12];
  assign out_m20 = out_r[M20];
  assign out_m21 = out_r[M21];
  assign out_m22 = out_r[M22];

  // ---- checks ----
  `ASSERT_NEXT(a_last_advance, vld_r[NSTG-2] && !in_stall, out_valid)
  `ASSERT_SAME(a_m01_range, out_valid, (out_m01 <= out_t'(OUT_LIM)) && (out_m01 >= -out_t'(OUT_LIM)))
  `ASSERT_SAME(a_m11_range, out_valid, (out_m11 <= out_t'(OUT_LIM)) && (out_m11 >= -out_t'(OUT_LIM)))

endmodule

[tb/e2rm_checker.sv]
// Checker for the Euler angle to rotation matrix unit: predicts every matrix and compares.
// Depends on e2rm_pkg for widths, types and the CORDIC constants.
module e2rm_checker
  import e2rm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_stall,
  input  angle_t in_angle_x,
  input  angle_t in_angle_y,
  input  angle_t in_angle_z,
  input  logic   out_valid,
  input  logic   out_stall,
  input  out_t   out_m00,
  input  out_t   out_m01,
  input  out_t   out_m02,
  input  out_t   out_m10,
  input  out_t   out_m11,
  input  out_t   out_m12,
  input  out_t   out_m20,
  input  out_t   out_m21,
  input  out_t   out_m22,
  output int     mismatch_count,
  output int     pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quadrant_e;

  typedef struct {
    longint c;
    longint s;
  } trig_t;

  typedef struct {
    angle_t ax;
    angle_t ay;
    angle_t az;
    out_t   entry [9];
  } matrix_t;

  string entry_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  matrix_t expected_matrices [$];
  int      mismatches = 0;
  int      waiting = 0;

  assign mismatch_count = mismatches;
  assign pending_count  = waiting;

  // Q30 x Q30 -> Q30, round half up with a floor shift
  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic trig_t cordic_sin_cos(angle_t a);
    logic [31:0] turn;
    logic [31:0] resid;
    quadrant_e   quad;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    int          i;
    trig_t       r;
    turn  = 32'(a) << (32 - ANGLE_BITS);
    quad  = quadrant_e'(2'((turn + 32'h2000_0000) >> 30));
    resid = turn - {quad, 30'b0};
    z = longint'(signed'(resid));
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TURN32[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TURN32[i]);
      end
    end
    case (quad)
      QUAD_0: begin
        r.c = x;
        r.s = y;
      end
      QUAD_90: begin
        r.c = -y;
        r.s = x;
      end
      QUAD_180: begin
        r.c = -x;
        r.s = -y;
      end
      default: begin
        r.c = y;
        r.s = -x;
      end
    endcase
    return r;
  endfunction

  // Q30 -> Q1.FRACTION_BITS, rounded then clamped to +/-1.0
  function automatic out_t to_entry(longint v);
    longint lim;
    longint o;
    lim = longint'(1) << FRACTION_BITS;
    o = v;
    if (ROUND_SHIFT > 0) begin
      o = (v + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    end
    if (o > lim) begin
      o = lim;
    end
    if (o < -lim) begin
      o = -lim;
    end
    return out_t'(o);
  endfunction

  function automatic matrix_t predict_matrix(angle_t ax, angle_t ay, angle_t az);
    trig_t   tx;
    trig_t   ty;
    trig_t   tz;
    longint  czsy;
    longint  szsy;
    matrix_t m;
    tx = cordic_sin_cos(ax);
    ty = cordic_sin_cos(ay);
    tz = cordic_sin_cos(az);
    czsy = q30_mul(tz.c, ty.s);
    szsy = q30_mul(tz.s, ty.s);
    m.ax = ax;
    m.ay = ay;
    m.az = az;
    m.entry[0] = to_entry(q30_mul(tz.c, ty.c));
    m.entry[1] = to_entry(q30_mul(czsy, tx.s) - q30_mul(tz.s, tx.c));
    m.entry[2] = to_entry(q30_mul(czsy, tx.c) + q30_mul(tz.s, tx.s));
    m.entry[3] = to_entry(q30_mul(tz.s, ty.c));
    m.entry[4] = to_entry(q30_mul(szsy, tx.s) + q30_mul(tz.c, tx.c));
    m.entry[5] = to_entry(q30_mul(szsy, tx.c) - q30_mul(tz.c, tx.s));
    m.entry[6] = to_entry(-ty.s);
    m.entry[7] = to_entry(q30_mul(ty.c, tx.s));
    m.entry[8] = to_entry(q30_mul(ty.c, tx.c));
    return m;
  endfunction

  always @(posedge clk) begin : monitor
    matrix_t want;
    out_t    got [9];
    bit      bad;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_matrices.push_back(predict_matrix(in_angle_x, in_angle_y, in_angle_z));
      end
      if (out_valid && !out_stall) begin
        got = '{out_m00, out_m01, out_m02, out_m10, out_m11, out_m12,
                out_m20, out_m21, out_m22};
        if (expected_matrices.size() == 0) begin
          $display("%0t: unexpected output word, m00 actual %0d", $time, out_m00);
          mismatches++;
        end else begin
          want = expected_matrices.pop_front();
          bad = 1'b0;
          for (int i = 0; i < 9; i++) begin
            if (got[i] !== want.entry[i]) begin
              $display("%0t: angles x=%h y=%h z=%h %s expected %0d actual %0d",
                       $time, want.ax, want.ay, want.az, entry_name[i],
                       want.entry[i], got[i]);
              bad = 1'b1;
            end
          end
          if (bad) begin
            mismatches++;
          end
        end
      end
      waiting = expected_matrices.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Top of the testbench for euler_to_rotation_matrix_unit: clock, reset, stimulus, verdict.
// Depends on e2rm_pkg, the unit itself and e2rm_checker, which does all prediction.
module tb_top;
  import e2rm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Handy angles as fractions of a full turn.
  localparam angle_t HALF    = angle_t'(1) << (ANGLE_BITS - 1);
  localparam angle_t QUARTER = angle_t'(1) << (ANGLE_BITS - 2);
  localparam angle_t EIGHTH  = angle_t'(1) << (ANGLE_BITS - 3);
  localparam angle_t MAXA    = '1;

  localparam int RANDOM_WORDS = 1450;
  localparam int QUIET_LIMIT  = 2000;  // well past the long hold plus pipe depth
  localparam int DRAIN_CYCLES = 60;    // pipe is 38 stages deep
  localparam int LONG_HOLD    = 180;   // deeper than the pipe, so in_stall must rise

  typedef enum int {ANG_UNIFORM, ANG_NEAR_OCTANT, ANG_EXTREME} angle_style_e;
  typedef enum int {RX_FLOW, RX_RANDOM, RX_TOGGLE, RX_HOLD} rx_mode_e;

  logic   clk;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  angle_t in_angle_x = '0;
  angle_t in_angle_y = '0;
  angle_t in_angle_z = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  out_t   out_m00, out_m01, out_m02;
  out_t   out_m10, out_m11, out_m12;
  out_t   out_m20, out_m21, out_m22;

  int mismatch_count;
  int pending_count;
  int quiet_cycles = 0;
  int burst_left = 1;

  euler_to_rotation_matrix_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_angle_x (in_angle_x),
    .in_angle_y (in_angle_y),
    .in_angle_z (in_angle_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_m00    (out_m00),
    .out_m01    (out_m01),
    .out_m02    (out_m02),
    .out_m10    (out_m10),
    .out_m11    (out_m11),
    .out_m12    (out_m12),
    .out_m20    (out_m20),
    .out_m21    (out_m21),
    .out_m22    (out_m22)
  );

  e2rm_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_angle_x     (in_angle_x),
    .in_angle_y     (in_angle_y),
    .in_angle_z     (in_angle_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_m00        (out_m00),
    .out_m01        (out_m01),
    .out_m02        (out_m02),
    .out_m10        (out_m10),
    .out_m11        (out_m11),
    .out_m12        (out_m12),
    .out_m20        (out_m20),
    .out_m21        (out_m21),
    .out_m22        (out_m22),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: any accepted word on either side resets the quiet count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One angle, drawn in one of three styles:
  //   uniform over the full turn (exercises every bit),
  //   within a few LSBs of an octant line (quadrant reduction edges),
  //   or one of the range extremes.
  function automatic angle_t pick_angle(angle_style_e style);
    angle_t a;
    case (style)
      ANG_NEAR_OCTANT: begin
        a = angle_t'($urandom_range(0, 7) * EIGHTH + $urandom_range(0, 8) - 4);
      end
      ANG_EXTREME: begin
        case ($urandom_range(0, 3))
          0: a = '0;
          1: a = MAXA;
          2: a = HALF;
          default: a = angle_t'(HALF - 1);
        endcase
      end
      default: begin
        a = angle_t'($urandom);
      end
    endcase
    return a;
  endfunction

  function automatic angle_style_e pick_style();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return ANG_UNIFORM;
    end else if (r < 85) begin
      return ANG_NEAR_OCTANT;
    end
    return ANG_EXTREME;
  endfunction

  // Offer one word. Called at a falling edge; returns at the falling edge
  // after the word was taken. A burst ends with an optional gap, which is
  // taken before the next word so valid is only lowered once per edge.
  task automatic send_angles(angle_t ax, angle_t ay, angle_t az);
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid   <= 1'b1;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: runs of free flow, coin-flip stalls, toggling and short holds.
  // A long hold comes round now and then while the sender keeps offering,
  // which backs the pipe up all the way to in_stall.
  initial begin : receiver
    rx_mode_e rx_mode;
    int       run_len;
    int       rx_cycles;
    int       next_long_hold;
    rx_cycles = 0;
    next_long_hold = 600;
    forever begin
      if (rx_cycles >= next_long_hold) begin
        rx_mode = RX_HOLD;
        run_len = LONG_HOLD;
        next_long_hold += 2500;
      end else begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        run_len = (rx_mode == RX_HOLD) ? $urandom_range(1, 8) : $urandom_range(10, 60);
      end
      repeat (run_len) begin
        @(negedge clk);
        case (rx_mode)
          RX_FLOW:   out_stall <= 1'b0;
          RX_RANDOM: out_stall <= 1'($urandom_range(0, 1));
          RX_TOGGLE: out_stall <= ~out_stall;
          default:   out_stall <= 1'b1;
        endcase
        rx_cycles++;
      end
    end
  end

  initial begin : stimulus
    angle_t a;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed: zero, each axis alone at a quarter turn, whole turn points,
    // octant lines where quadrant reduction flips, gimbal lock on y, the
    // top and bottom of the angle range and alternating bit patterns.
    send_angles('0, '0, '0);
    send_angles(QUARTER, '0, '0);
    send_angles('0, QUARTER, '0);
    send_angles('0, '0, QUARTER);
    send_angles(HALF, HALF, HALF);
    send_angles(angle_t'(3 * QUARTER), angle_t'(3 * QUARTER), angle_t'(3 * QUARTER));
    send_angles(MAXA, MAXA, MAXA);
    send_angles(angle_t'(1), angle_t'(1), angle_t'(1));
    send_angles(EIGHTH, EIGHTH, EIGHTH);
    send_angles(angle_t'(EIGHTH - 1), angle_t'(EIGHTH + 1), angle_t'(3 * EIGHTH));
    send_angles(angle_t'(HALF - 1), angle_t'(HALF + 1), angle_t'(QUARTER - 1));
    send_angles('0, QUARTER, QUARTER);
    send_angles(QUARTER, angle_t'(3 * QUARTER), EIGHTH);
    send_angles(angle_t'(5 * EIGHTH), angle_t'(7 * EIGHTH), angle_t'(3 * EIGHTH));
    send_angles(MAXA, '0, HALF);
    send_angles({(ANGLE_BITS / 2){2'b01}}, {(ANGLE_BITS / 2){2'b10}},
                {(ANGLE_BITS / 2){2'b01}});
    send_angles({(ANGLE_BITS / 2){2'b10}}, {(ANGLE_BITS / 2){2'b01}},
                {(ANGLE_BITS / 2){2'b10}});
    send_angles(MAXA, HALF, '0);

    // Random: mostly independent angles, sometimes all three the same.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        a = pick_angle(pick_style());
        send_angles(a, a, a);
      end else begin
        send_angles(pick_angle(pick_style()), pick_angle(pick_style()),
                    pick_angle(pick_style()));
      end
    end
    in_valid <= 1'b0;

    // Drain, then give the pipe time to show any stray word.
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
